>>> src/windowed_step_rate_meter_core_macros.svh
// Assertion macros used by the checker of the step rate meter.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef WINDOWED_STEP_RATE_METER_CORE_MACROS_SVH
`define WINDOWED_STEP_RATE_METER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSRM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> src/wsrm_pkg.sv
// Shared types and constants of the windowed step rate meter.
// Used by the controller, the datapath and the top level; no dependencies.
package wsrm_pkg;

    localparam int DEF_RING_DEPTH    = 16;
    localparam int TICKS_X16_PER_MIN = 960000;
    localparam int TICKS_W           = 20;
    localparam int CADENCE_W         = 16;
    localparam int TIME_W            = 32;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int MIN_STRIKES_W     = 5;
    localparam int MIN_SPAN_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_STRIKES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPAN    = 2'd1;

    localparam logic [MIN_STRIKES_W-1:0] MIN_STRIKES_RST = 5'd3;
    localparam logic [MIN_SPAN_W-1:0]    MIN_SPAN_RST    = 16'd600;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic eval;
        logic div_step;
        logic emit;
    } wsrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reportable;
        logic div_last;
    } wsrm_stat_t;

endpackage

>>> src/wsrm_ctrl.sv
// Sequencing state machine of the step rate meter.
// Depends on wsrm_pkg for the command and status types.
module wsrm_ctrl
    import wsrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  wsrm_stat_t stat,
    output wsrm_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.reportable ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/wsrm_dpath.sv
// Datapath of the step rate meter: timestamp ring, counters, settings,
// a bit-serial restoring divider and the result register. Uses wsrm_pkg.
module wsrm_dpath
    import wsrm_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wsrm_cmd_t              cmd,
    output wsrm_stat_t             stat,
    input  logic                   clear_all,
    input  logic [TIME_W-1:0]      strike_time_ms,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [CADENCE_W-1:0]   cadence_x16,
    output logic                   cadence_valid,
    output logic [TIME_W-1:0]      total_steps
);

    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int CMP_W      = (CNT_W > MIN_STRIKES_W) ? CNT_W : MIN_STRIKES_W;
    localparam int NUM_MAX    = (RING_DEPTH - 1) * TICKS_X16_PER_MIN;
    localparam int NUM_W      = $clog2(NUM_MAX + 1);
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    logic [TIME_W-1:0]        ring_mem [RING_DEPTH];

    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [TIME_W-1:0]        total_reg;
    logic [TIME_W-1:0]        total_next;
    logic [MIN_STRIKES_W-1:0] min_strikes_reg;
    logic [MIN_SPAN_W-1:0]    min_span_reg;

    logic [CNT_W:0]           old_sum;
    logic [CNT_W:0]           old_wrap;
    logic [TIME_W-1:0]        ts_reg;
    logic [TIME_W-1:0]        oldest_reg;

    logic [TIME_W-1:0]        span;
    logic [MIN_STRIKES_W-1:0] need;
    logic [MIN_SPAN_W-1:0]    span_floor;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W+TICKS_W-1:0] num_prod;

    logic [TIME_W-1:0]        span_reg;
    logic [TIME_W-1:0]        rem_reg;
    logic [NUM_W-1:0]         quot_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     report_reg;
    logic [TIME_W:0]          rem_shift;
    logic                     rem_ge;

    logic [CADENCE_W-1:0]     cadence_reg;
    logic                     valid_flag_reg;
    logic [TIME_W-1:0]        total_out_reg;
    logic [CADENCE_W-1:0]     cadence_sat;

    // Pointer and count updates for a strike; a clear empties the ring.
    always_comb
    begin
        slot_next  = (slot_reg == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        cnt_next   = (cnt_reg == CNT_W'(RING_DEPTH)) ? cnt_reg : cnt_reg + CNT_W'(1);
        total_next = total_reg + TIME_W'(1);
        if (clear_all)
        begin
            slot_next  = '0;
            cnt_next   = '0;
            total_next = '0;
        end
        old_sum  = (CNT_W+1)'(slot_next) + (CNT_W+1)'(RING_DEPTH) - (CNT_W+1)'(cnt_next);
        old_wrap = (old_sum >= (CNT_W+1)'(RING_DEPTH)) ?
                   old_sum - (CNT_W+1)'(RING_DEPTH) : old_sum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !clear_all)
        begin
            ring_mem[slot_reg] <= strike_time_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            oldest_reg <= ring_mem[old_wrap[SLOT_W-1:0]];
            ts_reg     <= strike_time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= '0;
            cnt_reg         <= '0;
            total_reg       <= '0;
            min_strikes_reg <= MIN_STRIKES_RST;
            min_span_reg    <= MIN_SPAN_RST;
        end
        else
        begin
            if (cmd.accept)
            begin
                slot_reg  <= slot_next;
                cnt_reg   <= cnt_next;
                total_reg <= total_next;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_STRIKES: min_strikes_reg <= cfg_data[MIN_STRIKES_W-1:0];
                    REG_MIN_SPAN:    min_span_reg    <= cfg_data[MIN_SPAN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Evaluation: span, reporting conditions and the dividend.
    always_comb
    begin
        span       = ts_reg - oldest_reg;
        need       = (min_strikes_reg < MIN_STRIKES_W'(2)) ? MIN_STRIKES_W'(2) : min_strikes_reg;
        span_floor = (min_span_reg == '0) ? MIN_SPAN_W'(1) : min_span_reg;
        cnt_m1     = cnt_reg - CNT_W'(1);
        num_prod   = (CNT_W+TICKS_W)'(cnt_m1) * (CNT_W+TICKS_W)'(TICKS_X16_PER_MIN);
        stat.reportable = (CMP_W'(cnt_reg) >= CMP_W'(need)) &&
                          (cnt_reg >= CNT_W'(2)) &&
                          (span >= TIME_W'(span_floor));
        stat.div_last   = (div_cnt_reg == DIV_CNT_W'(NUM_W - 1));
    end

    // One quotient bit per cycle, most significant first.
    assign rem_shift = {rem_reg, quot_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, span_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            report_reg  <= 1'b0;
        end
        else if (cmd.eval)
        begin
            div_cnt_reg <= '0;
            report_reg  <= stat.reportable;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            span_reg <= span;
            rem_reg  <= '0;
            quot_reg <= num_prod[NUM_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? TIME_W'(rem_shift - {1'b0, span_reg}) : rem_shift[TIME_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], rem_ge};
        end
    end

    // The quotient saturates at the largest 16-bit cadence.
    assign cadence_sat = (|quot_reg[NUM_W-1:CADENCE_W]) ? '1 : quot_reg[CADENCE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            cadence_reg    <= report_reg ? cadence_sat : '0;
            valid_flag_reg <= report_reg;
            total_out_reg  <= total_reg;
        end
    end

    assign cadence_x16   = cadence_reg;
    assign cadence_valid = valid_flag_reg;
    assign total_steps   = total_out_reg;

endmodule

>>> src/windowed_step_rate_meter_core.sv
// Windowed step rate meter, top level. Each input transfer carries either a
// foot strike timestamp in ms (tdata) or a clear command (tuser = 1). A strike
// is stored in a ring of the RING_DEPTH most recent timestamps, and every
// input transfer produces exactly one output transfer with the cadence in
// steps per minute times 16, a flag saying whether it is meaningful, and the
// wrapping step total since the last clear. The cadence is
// (stored - 1) * 960000 / (newest - oldest), truncated and saturated at 65535,
// and reads zero when too few strikes are stored or the span is shorter than
// min_span_ms. Items are handled one at a time, and the next item is taken only
// after the last one has reached the output register. A strike that can be
// reported passes the evaluation state and then the bit-serial restoring
// divider, which retires one quotient bit per cycle from a dividend of NUM_W
// bits (24 bits at the default depth of 16). A clear or an unreportable strike
// skips the divider and goes from evaluation straight to the output register.
// The output register decouples the two sides, so the next item is taken
// while a finished result still waits; a second finished result holds the
// controller until the first one has been transferred. Settings are written
// through the cfg channel, which is always ready and must only be used while
// idle.
module windowed_step_rate_meter_core
    import wsrm_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] strike_time_ms
    input  logic                   s_axis_tuser,   // [0] clear_all
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [47:0]            m_axis_tdata,   // [15:0] cadence_x16, [47:16] total_steps
    output logic                   m_axis_tuser,   // [0] cadence_valid
    // Settings write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    wsrm_cmd_t            cmd;
    wsrm_stat_t           stat;
    logic [CADENCE_W-1:0] cadence_x16;
    logic [TIME_W-1:0]    total_steps;

    // Settings are plain register writes and never stall.
    assign cfg_ready = 1'b1;

    wsrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wsrm_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .clear_all      (s_axis_tuser),
        .strike_time_ms (s_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cadence_x16    (cadence_x16),
        .cadence_valid  (m_axis_tuser),
        .total_steps    (total_steps)
    );

    assign m_axis_tdata = {total_steps, cadence_x16};

endmodule

>>> src/wsrm_checker.sv
// Port-level checks of the step rate meter, bound to the top level.
// Depends on windowed_step_rate_meter_core_macros.svh.
`include "windowed_step_rate_meter_core_macros.svh"

module wsrm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // An unreported cadence always reads zero.
    `WSRM_ASSERT_SAME(a_zero_when_unreported, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:0] == 16'd0)

    // Only one item is in work at a time, so ready drops after a transfer.
    `WSRM_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A result follows even a clear transfer only after the evaluation and done
    // states, so no output can appear in the cycle right after an input transfer
    // unless one was already waiting.
    `WSRM_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)

    // A stalled result holds its payload.
    `WSRM_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind windowed_step_rate_meter_core wsrm_checker u_wsrm_checker (.*);
